[rtl/fal_pkg.sv]
// Shared types and constants for the frame allocator with global LRU and limits.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fal_pkg;

    // Table size default and fixed field widths.
    localparam int FRAMES_DEF     = 64;
    localparam int PROCESSES      = 4;
    localparam int NUM_PROC_SLOTS = 4;
    localparam int PID_W          = 2;
    localparam int PAGE_BITS      = 20;
    localparam int FRAME_W        = 6;
    localparam int LIMIT_W        = 7;
    localparam int STAMP_W        = 32;

    // Stream and register port widths.
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 3;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes: upper limits first, then lower limits.
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BASE = 3'd4;

    localparam logic [LIMIT_W-1:0] UPPER_RESET = 7'd64;
    localparam logic [LIMIT_W-1:0] LOWER_RESET = 7'd0;

    // Item kinds carried in the input tuser.
    localparam logic MODE_TOUCH = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef logic [LIMIT_W-1:0] limit_t;

    typedef struct packed {
        limit_t [NUM_PROC_SLOTS-1:0] upper;
        limit_t [NUM_PROC_SLOTS-1:0] lower;
    } limits_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic touch;
        logic reject;
        logic scan_start;
        logic scan_step;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic pid_ok;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/frame_allocator_global_lru_limits_top.sv]
// Top level of the frame allocator with global LRU replacement and working-set limits.
// Depends on fal_pkg, fal_cfg, fal_ctrl and fal_dp.
//
//  Channel   Direction  Handshake                   Contents
//  s_*       in         s_tvalid / s_tready         touch or allocate request word
//  m_*       out        m_tvalid / m_tready         result word
//  apb       in/out     psel, penable, pwrite       upper and lower limit registers
//
// A touch finishes in the execute state; an allocate passes through the scan, which reads one
// frame per cycle from the frame table, and then commits.
// A finished result sits in the output register; the next word is accepted meanwhile.
// A stalled output holds the following result in the controller until the register frees.
// Reset clears the valid bits, resident counts and use clock at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module frame_allocator_global_lru_limits_top #(
    parameter int FRAMES = fal_pkg::FRAMES_DEF   // 2 to 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Request: pid [1:0], vpn [21:2], touch_frame [27:22], zero fill above
    input  wire logic [fal_pkg::S_TDATA_W-1:0]  s_tdata,
    // Request: mode (0 touch, 1 allocate)
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Result: frame [5:0], evicted_pid [7:6], evicted_vpn [27:8], zero fill above
    output logic      [fal_pkg::M_TDATA_W-1:0]  m_tdata,
    // Result: ok [0], took_free [1], evicted [2]
    output logic      [fal_pkg::M_TUSER_W-1:0]  m_tuser,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fal_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [fal_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [fal_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import fal_pkg::*;

    limits_t    limits;
    dp_cmd_t    cmd;
    dp_status_t sts;

    fal_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    fal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fal_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .limits   (limits),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

[rtl/fal_cfg.sv]
// Configuration registers (upper and lower resident limits) behind the APB-style port.
// Depends on fal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fal_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fal_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [fal_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [fal_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output fal_pkg::limits_t                    limits
);
    import fal_pkg::*;

    limit_t [NUM_PROC_SLOTS-1:0] upper_reg;
    limit_t [NUM_PROC_SLOTS-1:0] lower_reg;
    logic   [CFG_IDX_W-1:0]      idx;
    logic   [1:0]                slot;
    logic                        wr_en;
    logic                        is_upper;

    assign pready   = 1'b1;
    assign idx      = paddr[CFG_ADDR_W-1:2];
    assign slot     = idx[1:0];
    // Upper limits sit from index zero up to the first lower limit.
    assign is_upper = (idx < REG_LOWER_BASE);
    assign wr_en    = psel && penable && pwrite && pready;

    // Register write on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= {NUM_PROC_SLOTS{UPPER_RESET}};
            lower_reg <= {NUM_PROC_SLOTS{LOWER_RESET}};
        end
        else if (wr_en)
        begin
            if (is_upper)
                upper_reg[slot] <= pwdata[LIMIT_W-1:0];
            else
                lower_reg[slot] <= pwdata[LIMIT_W-1:0];
        end
    end

    // Read back the addressed register.
    always_comb
    begin
        if (is_upper)
            prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, upper_reg[slot]};
        else
            prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, lower_reg[slot]};
    end

    assign limits.upper = upper_reg;
    assign limits.lower = lower_reg;

endmodule

`default_nettype wire

[rtl/fal_ctrl.sv]
// Controller state machine: sequences input acceptance, the frame scan and the commit.
// Depends on fal_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fal_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire fal_pkg::dp_status_t sts,
    output fal_pkg::dp_cmd_t         cmd
);
    import fal_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.mode == MODE_ALLOC && sts.pid_ok)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (sts.out_free)
                begin
                    // Touches and unknown processes finish at once.
                    if (sts.mode == MODE_TOUCH)
                        cmd.touch = 1'b1;
                    else
                        cmd.reject = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A word is taken only while idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    // A scan always ends in a commit.
    a_scan_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && sts.scan_last) |=> (state_reg == ST_COMMIT))
        else $error("scan did not reach commit");

    // Results are produced only when the output register can take them.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.touch || cmd.reject) |-> sts.out_free)
        else $error("result produced while output register busy");

endmodule

`default_nettype wire

[rtl/fal_dp.sv]
// Datapath: frame table memories, valid bits, resident counts, use clock, scan and output register.
// Depends on fal_pkg; commanded by fal_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fal_dp #(
    parameter int FRAMES = fal_pkg::FRAMES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [fal_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [fal_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [fal_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire fal_pkg::limits_t              limits,
    input  wire fal_pkg::dp_cmd_t              cmd,
    output fal_pkg::dp_status_t                sts
);
    import fal_pkg::*;

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int META_W = PID_W + PAGE_BITS;
    localparam logic [CW-1:0]      SCAN_END   = CW'(FRAMES);
    localparam logic [FRAME_W:0]   FRAMES_LIM = (FRAME_W + 1)'(FRAMES);
    localparam logic [PID_W:0]     PROC_LIM   = (PID_W + 1)'(PROCESSES);

    // Frame table storage.
    logic [META_W-1:0]  meta_mem  [FRAMES];
    logic [STAMP_W-1:0] stamp_mem [FRAMES];
    logic [FRAMES-1:0]  valid_reg;

    // Current item.
    logic                 mode_reg;
    logic [PID_W-1:0]     pid_reg;
    logic [PAGE_BITS-1:0] vpn_reg;
    logic [FRAME_W-1:0]   tf_reg;
    logic                 at_upper_reg;

    // Per-process counts and the use clock.
    limit_t [NUM_PROC_SLOTS-1:0] count_reg;
    limit_t [NUM_PROC_SLOTS-1:0] count_next;
    logic [STAMP_W-1:0]          clock_reg;
    logic [STAMP_W-1:0]          clock_next;
    logic [STAMP_W-1:0]          clock_inc;

    // Scan state.
    logic [CW-1:0]        scan_cnt_reg;
    logic                 eval_vld_reg;
    logic [FW-1:0]        eval_idx_reg;
    logic [META_W-1:0]    rd_meta_reg;
    logic [STAMP_W-1:0]   rd_stamp_reg;
    logic                 free_found_reg;
    logic [FW-1:0]        free_idx_reg;
    logic                 best_found_reg;
    logic [FW-1:0]        best_idx_reg;
    logic [STAMP_W-1:0]   best_stamp_reg;
    logic [PID_W-1:0]     best_owner_reg;
    logic [PAGE_BITS-1:0] best_page_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic                 out_ok_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic                 out_took_free_reg;
    logic                 out_evicted_reg;
    logic [PID_W-1:0]     out_pid_reg;
    logic [PAGE_BITS-1:0] out_vpn_reg;

    // Combinational helpers.
    logic                 rd_en;
    logic [FW-1:0]        rd_addr;
    logic [PID_W-1:0]     rd_owner;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 e_valid;
    logic                 e_own;
    logic                 eligible;
    logic                 better;
    logic                 take_free;
    logic                 alloc_free;
    logic                 alloc_evict;
    logic                 alloc_any;
    logic [FW-1:0]        sel_idx;
    logic                 touch_ok;
    logic                 stamp_we;
    logic [FW-1:0]        stamp_addr;
    logic                 produce;
    logic [LIMIT_W+1:0]   count_sum;

    assign sts.mode      = mode_reg;
    assign sts.pid_ok    = ({1'b0, pid_reg} < PROC_LIM);
    assign sts.scan_last = (scan_cnt_reg == SCAN_END);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Load the incoming word: pid, vpn and touch frame from tdata, mode from tuser.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tuser;
            pid_reg  <= s_tdata[PID_W-1:0];
            vpn_reg  <= s_tdata[PID_W+PAGE_BITS-1:PID_W];
            tf_reg   <= s_tdata[PID_W+PAGE_BITS+FRAME_W-1:PID_W+PAGE_BITS];
        end
    end

    // Scan read port: one frame per cycle.
    assign rd_en   = cmd.scan_step && (scan_cnt_reg < SCAN_END);
    assign rd_addr = scan_cnt_reg[FW-1:0];

    // Evaluate the frame read in the previous cycle.
    assign rd_owner  = rd_meta_reg[META_W-1:PAGE_BITS];
    assign rd_page   = rd_meta_reg[PAGE_BITS-1:0];
    assign e_valid   = valid_reg[eval_idx_reg];
    assign e_own     = (rd_owner == pid_reg);
    assign eligible  = eval_vld_reg && e_valid && !(at_upper_reg && !e_own)
                     && !(!e_own && (count_reg[rd_owner] <= limits.lower[rd_owner]));
    assign better    = eligible && (!best_found_reg || (rd_stamp_reg < best_stamp_reg));
    assign take_free = eval_vld_reg && !e_valid && !free_found_reg;

    // Scan counters and candidate tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            eval_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_cnt_reg   <= '0;
            eval_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            eval_vld_reg <= rd_en;
            if (rd_en)
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            if (take_free)
                free_found_reg <= 1'b1;
            if (better)
                best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            at_upper_reg <= (count_reg[pid_reg] >= limits.upper[pid_reg]);
        if (rd_en)
            eval_idx_reg <= rd_addr;
        if (cmd.scan_step && take_free)
            free_idx_reg <= eval_idx_reg;
        if (cmd.scan_step && better)
        begin
            best_idx_reg   <= eval_idx_reg;
            best_stamp_reg <= rd_stamp_reg;
            best_owner_reg <= rd_owner;
            best_page_reg  <= rd_page;
        end
    end

    // Commit decision.
    assign alloc_free  = cmd.commit && !at_upper_reg && free_found_reg;
    assign alloc_evict = cmd.commit && !alloc_free && best_found_reg;
    assign alloc_any   = alloc_free || alloc_evict;
    assign sel_idx     = alloc_free ? free_idx_reg : best_idx_reg;
    assign touch_ok    = cmd.touch && ({1'b0, tf_reg} < FRAMES_LIM);
    assign stamp_we    = alloc_any || touch_ok;
    assign stamp_addr  = touch_ok ? tf_reg[FW-1:0] : sel_idx;
    assign produce     = cmd.touch || cmd.reject || cmd.commit;

    // Saturating use clock.
    assign clock_inc  = (clock_reg == STAMP_MAX) ? clock_reg : clock_reg + STAMP_W'(1);
    assign clock_next = stamp_we ? clock_inc : clock_reg;

    // Resident counts: free takes add one; eviction from another process moves one.
    always_comb
    begin
        for (int p = 0; p < NUM_PROC_SLOTS; p++)
        begin
            count_next[p] = count_reg[p];
            if (alloc_free && pid_reg == PID_W'(p))
                count_next[p] = count_reg[p] + LIMIT_W'(1);
            if (alloc_evict && best_owner_reg != pid_reg)
            begin
                if (best_owner_reg == PID_W'(p) && count_reg[p] != '0)
                    count_next[p] = count_reg[p] - LIMIT_W'(1);
                if (pid_reg == PID_W'(p))
                    count_next[p] = count_reg[p] + LIMIT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (alloc_free)
                valid_reg[sel_idx] <= 1'b1;
            count_reg <= count_next;
            clock_reg <= clock_next;
        end
    end

    // Owner and page memory.
    always_ff @(posedge clk)
    begin
        if (alloc_any)
            meta_mem[sel_idx] <= {pid_reg, vpn_reg};
        if (rd_en)
            rd_meta_reg <= meta_mem[rd_addr];
    end

    // Use stamp memory.
    always_ff @(posedge clk)
    begin
        if (stamp_we)
            stamp_mem[stamp_addr] <= clock_inc;
        if (rd_en)
            rd_stamp_reg <= stamp_mem[rd_addr];
    end

    // Output register: loaded when a result is produced, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (produce)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_ok_reg        <= touch_ok || alloc_any;
            out_frame_reg     <= alloc_any ? FRAME_W'(sel_idx) : '0;
            out_took_free_reg <= alloc_free;
            out_evicted_reg   <= alloc_evict;
            out_pid_reg       <= alloc_evict ? best_owner_reg : '0;
            out_vpn_reg       <= alloc_evict ? best_page_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-FRAME_W-PID_W-PAGE_BITS){1'b0}},
                       out_vpn_reg, out_pid_reg, out_frame_reg};
    assign m_tuser  = {out_evicted_reg, out_took_free_reg, out_ok_reg};

    // Total of the resident counts, for checking against the valid bits.
    always_comb
    begin
        count_sum = '0;
        for (int p = 0; p < NUM_PROC_SLOTS; p++)
            count_sum = count_sum + (LIMIT_W + 2)'(count_reg[p]);
    end

    // Every valid frame belongs to exactly one process count.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_sum == (LIMIT_W + 2)'($countones(valid_reg)))
        else $error("resident counts disagree with valid frames");

    // The use clock never goes backwards.
    a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
        clock_reg >= $past(clock_reg))
        else $error("use clock decreased");

    // A result never claims both a free frame and an eviction.
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(out_took_free_reg && out_evicted_reg))
        else $error("free take and eviction in one result");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for frame_allocator_global_lru_limits_top: touch and allocate words
// are checked against a cycle-free model of the frame table, as limit settings are varied.
// Depends on fal_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
    import fal_pkg::*;

    localparam int ITEMS_PER_PHASE = 158;
    localparam int PHASES          = 6;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 80;

    // One expected result word.
    typedef struct packed {
        logic                 ok;
        logic [FRAME_W-1:0]   frame;
        logic                 took_free;
        logic                 evicted;
        logic [PID_W-1:0]     ev_pid;
        logic [PAGE_BITS-1:0] ev_vpn;
    } grant_t;

    // Frame table model plus the queue of grants still owed by the block.
    class alloc_checker;
        bit                   frame_used [FRAMES_DEF];
        bit [PID_W-1:0]       frame_pid  [FRAMES_DEF];
        bit [PAGE_BITS-1:0]   frame_vpn  [FRAMES_DEF];
        bit [STAMP_W-1:0]     frame_seen [FRAMES_DEF];
        bit [LIMIT_W-1:0]     resident   [PROCESSES];
        bit [STAMP_W-1:0]     use_tick;
        limit_t               upper      [PROCESSES];
        limit_t               lower      [PROCESSES];
        grant_t               grants_due [$];
        int                   errors;
        int                   n_touch;
        int                   n_free;
        int                   n_evict;
        int                   n_refused;

        function new();
            for (int p = 0; p < PROCESSES; p++)
            begin
                upper[p]    = UPPER_RESET;
                lower[p]    = LOWER_RESET;
                resident[p] = '0;
            end
            for (int f = 0; f < FRAMES_DEF; f++)
                frame_used[f] = 1'b0;
            use_tick = '0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, limit_t value);
            if (idx < REG_LOWER_BASE)
                upper[idx - REG_UPPER_BASE] = value;
            else
                lower[idx - REG_LOWER_BASE] = value;
        endfunction

        // The use clock saturates rather than wrapping.
        function void stamp(int f);
            if (use_tick != STAMP_MAX)
                use_tick++;
            frame_seen[f] = use_tick;
        endfunction

        function grant_t predict_grant(logic mode, logic [PID_W-1:0] pid,
                                       logic [PAGE_BITS-1:0] vpn, logic [FRAME_W-1:0] tf);
            grant_t             g;
            bit                 at_top;
            bit                 found;
            int                 pick;
            bit [STAMP_W-1:0]   oldest;
            bit [PID_W-1:0]     prev;

            g      = '0;
            found  = 1'b0;
            pick   = 0;
            oldest = '0;
            if (mode == MODE_TOUCH)
            begin
                stamp(tf);
                g.ok = 1'b1;
                return g;
            end

            // Below the upper limit the lowest free frame is taken first.
            at_top = resident[pid] >= upper[pid];
            if (!at_top)
            begin
                for (int f = 0; f < FRAMES_DEF; f++)
                begin
                    if (!frame_used[f])
                    begin
                        frame_used[f] = 1'b1;
                        frame_pid[f]  = pid;
                        frame_vpn[f]  = vpn;
                        stamp(f);
                        resident[pid]++;
                        g.ok        = 1'b1;
                        g.frame     = FRAME_W'(f);
                        g.took_free = 1'b1;
                        return g;
                    end
                end
            end

            // Oldest eligible frame, earliest index on a tie.
            for (int f = 0; f < FRAMES_DEF; f++)
            begin
                if (!frame_used[f])
                    continue;
                if (at_top && frame_pid[f] != pid)
                    continue;
                if (frame_pid[f] != pid && resident[frame_pid[f]] <= lower[frame_pid[f]])
                    continue;
                if (!found || frame_seen[f] < oldest)
                begin
                    pick   = f;
                    oldest = frame_seen[f];
                    found  = 1'b1;
                end
            end
            if (!found)
                return g;

            prev      = frame_pid[pick];
            g.ok      = 1'b1;
            g.frame   = FRAME_W'(pick);
            g.evicted = 1'b1;
            g.ev_pid  = prev;
            g.ev_vpn  = frame_vpn[pick];
            if (prev != pid)
            begin
                if (resident[prev] != 0)
                    resident[prev]--;
                resident[pid]++;
            end
            frame_pid[pick] = pid;
            frame_vpn[pick] = vpn;
            stamp(pick);
            return g;
        endfunction

        function void note_request(logic mode, logic [PID_W-1:0] pid,
                                   logic [PAGE_BITS-1:0] vpn, logic [FRAME_W-1:0] tf);
            grant_t g;

            g = predict_grant(mode, pid, vpn, tf);
            grants_due.push_back(g);
            if (mode == MODE_TOUCH)
                n_touch++;
            else if (!g.ok)
                n_refused++;
            else if (g.took_free)
                n_free++;
            else
                n_evict++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            grant_t g;

            if (grants_due.size() == 0)
            begin
                $error("result word with no request outstanding: tdata %h tuser %b",
                       tdata, tuser);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            compare_field("ok",          g.ok,        tuser[0]);
            compare_field("took_free",   g.took_free, tuser[1]);
            compare_field("evicted",     g.evicted,   tuser[2]);
            compare_field("frame",       g.frame,     tdata[5:0]);
            compare_field("evicted_pid", g.ev_pid,    tdata[7:6]);
            compare_field("evicted_vpn", g.ev_vpn,    tdata[27:8]);
        endfunction

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    alloc_checker           sb;
    bit                     idle_on;
    bit                     hold_request;
    int                     cycle_count;
    limit_t                 next_upper [PROCESSES];
    limit_t                 next_lower [PROCESSES];

    frame_allocator_global_lru_limits_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),      // pid [1:0], vpn [21:2], touch_frame [27:22]
        .s_tuser  (s_tuser),      // mode [0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),      // frame [5:0], evicted_pid [7:6], evicted_vpn [27:8]
        .m_tuser  (m_tuser),      // ok [0], took_free [1], evicted [2]
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: check each accepted word, then choose the next ready value.
    initial
    begin : result_side
        int hold_left;

        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < 28);
        end
    end

    // Offer one request word and wait until it is taken.
    task automatic offer_request(logic mode, logic [PID_W-1:0] pid,
                                 logic [PAGE_BITS-1:0] vpn, logic [FRAME_W-1:0] tf);
        while (idle_on && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, tf, vpn, pid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(mode, pid, vpn, tf);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write one limit register, then read it back.
    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, limit_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(CFG_DATA_W-LIMIT_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_limit(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(CFG_DATA_W-LIMIT_W){1'b0}}, value})
        begin
            $error("limit register %0d: expected %0d, got %0d", idx, value, prdata);
            sb.errors++;
        end
    endtask

    task automatic write_all_limits();
        for (int p = 0; p < PROCESSES; p++)
        begin
            write_limit(CFG_IDX_W'(REG_UPPER_BASE + p), next_upper[p]);
            write_limit(CFG_IDX_W'(REG_LOWER_BASE + p), next_lower[p]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence: reset, directed words, then random phases under varied limits.
    initial
    begin : stimulus
        int n_rand;
        int victim;

        sb           = new();
        idle_on      = 1'b1;
        hold_request = 1'b0;
        n_rand       = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= MODE_TOUCH;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Touches of unused frames, first allocations into free frames, then two more touches.
        offer_request(MODE_TOUCH, 2'd0, 20'h00000, 6'd0);
        offer_request(MODE_TOUCH, 2'd3, 20'hFFFFF, 6'd63);
        offer_request(MODE_ALLOC, 2'd0, 20'h00000, 6'd0);
        offer_request(MODE_ALLOC, 2'd3, 20'hFFFFF, 6'd63);
        offer_request(MODE_ALLOC, 2'd1, 20'h55555, 6'd21);
        offer_request(MODE_ALLOC, 2'd0, 20'hAAAAA, 6'd42);
        offer_request(MODE_TOUCH, 2'd1, 20'h12345, 6'd1);
        offer_request(MODE_TOUCH, 2'd2, 20'h00001, 6'd40);
        drain();

        // Tight limits: own-page replacement, refusal with no eligible frame.
        next_upper = '{7'd2, 7'd0, 7'd0, 7'd64};
        next_lower = '{7'd0, 7'd64, 7'd1, 7'd64};
        write_all_limits();
        offer_request(MODE_ALLOC, 2'd0, 20'h0F0F0, 6'd0);
        offer_request(MODE_ALLOC, 2'd0, 20'hF0F0F, 6'd0);
        offer_request(MODE_ALLOC, 2'd1, 20'h00003, 6'd0);
        offer_request(MODE_ALLOC, 2'd2, 20'h00007, 6'd0);
        offer_request(MODE_ALLOC, 2'd3, 20'h80000, 6'd0);
        offer_request(MODE_TOUCH, 2'd0, 20'h00000, 6'd2);
        offer_request(MODE_TOUCH, 2'd0, 20'h00000, 6'd3);
        drain();

        // Random phases, each under its own limit setting.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            victim = $urandom_range(PROCESSES-1);
            for (int p = 0; p < PROCESSES; p++)
            begin
                case (phase)
                    0:
                    begin
                        next_upper[p] = UPPER_RESET;
                        next_lower[p] = LOWER_RESET;
                    end
                    1:
                    begin
                        next_upper[p] = limit_t'($urandom_range(40, 8));
                        next_lower[p] = limit_t'($urandom_range(12, 0));
                    end
                    2:
                    begin
                        next_upper[p] = 7'd64;
                        next_lower[p] = (p == victim) ? 7'd64 : 7'd0;
                    end
                    3:
                    begin
                        next_upper[p] = limit_t'($urandom_range(20, 0));
                        next_lower[p] = limit_t'($urandom_range(20, 0));
                    end
                    4:
                    begin
                        next_upper[p] = limit_t'($urandom_range(64, 0));
                        next_lower[p] = limit_t'($urandom_range(64, 0));
                    end
                    default:
                    begin
                        next_upper[p] = (p == victim) ? 7'd0 : 7'd64;
                        next_lower[p] = limit_t'($urandom_range(30, 0));
                    end
                endcase
            end
            write_all_limits();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // One long output hold-off, and one stretch with no idling.
                if (n_rand == 250)
                    hold_request = 1'b1;
                idle_on = !(n_rand >= 400 && n_rand < 560);
                offer_request(($urandom_range(99) < 55) ? MODE_ALLOC : MODE_TOUCH,
                              PID_W'($urandom_range(PROCESSES-1)), PAGE_BITS'($urandom),
                              FRAME_W'($urandom_range(FRAMES_DEF-1)));
                n_rand++;
            end
            drain();
        end

        // Let any stray word show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d words: %0d touches, %0d free, %0d evicted, %0d refused,",
                 sb.n_touch + sb.n_free + sb.n_evict + sb.n_refused,
                 sb.n_touch, sb.n_free, sb.n_evict, sb.n_refused);
        $display("across %0d limit settings with one long output hold-off.", PHASES + 2);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
